// ===== src/assert_macros.svh =====
// Assertion macros for the RTL files.
// Depends on nothing; included by the top level, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion lbl failed");

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion lbl failed");

`endif

// ===== src/prqa_pkg.sv =====
// Shared types and constants for the progression range add / point query block.
// No dependencies.
`timescale 1ns / 1ps
package prqa_pkg;
   localparam int POS_W = 11;
   localparam int VAL_W = 32;
   localparam int SUM_W = 64;
   localparam int IDX_W = 12;    // update points reach range_end + 2
   localparam int SLOTS = 3;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_PROG  = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;
   localparam logic [1:0] CMD_SPARE = 2'd3;

   localparam logic [POS_W-1:0] COUNT_RESET = 11'd1024;

   // Up to three Fenwick updates on the pair of trees, or one query
   typedef struct packed {
      logic                              query;
      logic [POS_W-1:0]                  qpos;
      logic [SLOTS-1:0]                  en;
      logic [SLOTS-1:0][IDX_W-1:0]       idx;
      logic [SLOTS-1:0][SUM_W-1:0]       d1;
      logic [SLOTS-1:0][SUM_W-1:0]       d2;
   } plan_type;
endpackage

// ===== src/prqa_if.sv =====
// Channel interfaces: request, response and register write.
// Depends on prqa_pkg.
`timescale 1ns / 1ps
interface prqa_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           cmd;
   logic [prqa_pkg::POS_W-1:0]           position;
   logic [prqa_pkg::POS_W-1:0]           range_end;
   logic signed [prqa_pkg::VAL_W-1:0]    load_value;
   modport source (output valid, cmd, position, range_end, load_value, input ready);
   modport sink   (input valid, cmd, position, range_end, load_value, output ready);
endinterface

interface prqa_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [prqa_pkg::SUM_W-1:0]    point_value;
   modport source (output valid, point_value, input ready);
   modport sink   (input valid, point_value, output ready);
endinterface

interface prqa_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [prqa_pkg::POS_W-1:0]           element_count;
   modport source (output valid, element_count, input ready);
   modport sink   (input valid, element_count, output ready);
endinterface

// ===== src/prqa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module prqa_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end
endmodule

// ===== src/prqa_prep.sv =====
// Item decode: range checks and Fenwick update deltas, registered into a plan.
// Depends on prqa_pkg; holds the last loaded value.
`timescale 1ns / 1ps
module prqa_prep #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [1:0]                        cmd,
   input  logic [prqa_pkg::POS_W-1:0]        position,
   input  logic [prqa_pkg::POS_W-1:0]        range_end,
   input  logic signed [prqa_pkg::VAL_W-1:0] load_value,
   input  logic [prqa_pkg::POS_W-1:0]        count,
   output prqa_pkg::plan_type                plan_ff
);
   localparam int CW   = $clog2(MAX_ELEMENTS + 1);
   localparam int CMPW = (CW > prqa_pkg::IDX_W) ? CW : prqa_pkg::IDX_W;
   localparam logic [CMPW-1:0] MAX_C = CMPW'(MAX_ELEMENTS);
   localparam int SW = prqa_pkg::SUM_W;
   localparam int PW = 2 * prqa_pkg::IDX_W;

   logic [prqa_pkg::VAL_W-1:0] prev_ff, prev_in;
   prqa_pkg::plan_type         plan_in;
   logic [prqa_pkg::POS_W-1:0] n;
   logic [prqa_pkg::IDX_W-1:0] p12, e12, n12, pm1, len, len1, r1, r2;
   logic [SW-1:0]              now_v, before_v, v, prod_a, prod_b;
   logic [PW-1:0]              small_a, small_b;
   logic                       load_ok, prog_ok;

   always_comb begin
      if (count == '0) begin
         n = prqa_pkg::POS_W'(1);
      end else if (CMPW'(count) > MAX_C) begin
         n = MAX_C[prqa_pkg::POS_W-1:0];
      end else begin
         n = count;
      end
      p12  = {1'b0, position};
      e12  = {1'b0, range_end};
      n12  = {1'b0, n};
      pm1  = p12 - 1'b1;
      len  = e12 - p12 + 1'b1;
      len1 = len + 1'b1;
      r1   = e12 + 1'b1;
      r2   = e12 + 2'd2;

      now_v    = {{(SW - prqa_pkg::VAL_W){load_value[prqa_pkg::VAL_W-1]}}, load_value};
      before_v = {{(SW - prqa_pkg::VAL_W){prev_ff[prqa_pkg::VAL_W-1]}}, prev_ff};
      v        = now_v - before_v;
      prod_a   = v * SW'(pm1);
      prod_b   = v * SW'(p12);
      small_a  = e12 * len1;
      small_b  = len * r1;

      load_ok = (position != '0) && (p12 <= n12);
      prog_ok = (position != '0) && (position <= range_end) && (e12 <= n12);

      plan_in       = '0;
      plan_in.query = (cmd == prqa_pkg::CMD_QUERY);
      plan_in.qpos  = (p12 > n12) ? n : position;
      prev_in       = prev_ff;

      case (cmd)
         prqa_pkg::CMD_LOAD: begin
            if (load_ok) begin
               plan_in.en     = 3'b011;
               plan_in.idx[0] = p12;
               plan_in.d1[0]  = v;
               plan_in.d2[0]  = prod_a;
               plan_in.idx[1] = p12 + 1'b1;
               plan_in.d1[1]  = SW'(0) - v;
               plan_in.d2[1]  = SW'(0) - prod_b;
               prev_in        = load_value;
            end
         end
         prqa_pkg::CMD_PROG: begin
            if (prog_ok) begin
               plan_in.idx[0] = p12;
               plan_in.d1[0]  = SW'(1);
               plan_in.d2[0]  = SW'(pm1);
               plan_in.idx[1] = r1;
               if (e12 < n12) begin
                  // range end plus point subtract of len at R+1
                  plan_in.en     = 3'b111;
                  plan_in.d1[1]  = SW'(0) - SW'(len1);
                  plan_in.d2[1]  = SW'(0) - SW'(small_a);
                  plan_in.idx[2] = r2;
                  plan_in.d1[2]  = SW'(len);
                  plan_in.d2[2]  = SW'(small_b);
               end else begin
                  plan_in.en     = 3'b011;
                  plan_in.d1[1]  = SW'(0) - SW'(1);
                  plan_in.d2[1]  = SW'(0) - SW'(e12);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else if (start) begin
         prev_ff <= prev_in;
      end
      if (start) begin
         plan_ff <= plan_in;
      end
   end
endmodule

// ===== src/progression_range_add_point_query.sv =====
// Top level: two Fenwick trees over the difference array in one RAM, walked
// by a read-modify-write sequencer. Depends on prqa_pkg, prqa_if, prqa_prep, prqa_ram.
//
//  channel  | dir | payload
//  req_ch   | in  | cmd, position, range_end, load_value
//  rsp_ch   | out | point_value (queries only)
//  csr_ch   | in  | element_count
//
// After reset the RAM is zeroed, one entry a cycle; no request is taken meanwhile.
// An update item makes two or three walks of up to log2(MAX_ELEMENTS)+1 Fenwick nodes;
// each node is a RAM read and then a write-back. A query reads and accumulates each
// node, then multiplies and forms the result.
// A finished result waits in the output register; a new request is taken meanwhile.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module progression_range_add_point_query #(
   parameter int MAX_ELEMENTS = 1024
) (
   input logic        clock,
   input logic        reset,
   prqa_req_if.sink   req_ch,
   prqa_rsp_if.source rsp_ch,
   prqa_csr_if.sink   csr_ch
);
   localparam int AW   = $clog2(MAX_ELEMENTS);
   localparam int CW   = $clog2(MAX_ELEMENTS + 1);
   localparam int CMPW = (CW > prqa_pkg::IDX_W) ? CW : prqa_pkg::IDX_W;
   localparam int IW   = CMPW + 1;
   localparam logic [IW-1:0] MAX_I  = IW'(MAX_ELEMENTS);
   localparam logic [AW-1:0] LAST_A = AW'(MAX_ELEMENTS - 1);
   localparam int SW = prqa_pkg::SUM_W;

   typedef enum logic [9:0] {
      S_CLEAR = 10'b0000000001,
      S_IDLE  = 10'b0000000010,
      S_PREP  = 10'b0000000100,
      S_NEXT  = 10'b0000001000,
      S_RD    = 10'b0000010000,
      S_WR    = 10'b0000100000,
      S_QRD   = 10'b0001000000,
      S_QACC  = 10'b0010000000,
      S_MUL   = 10'b0100000000,
      S_FIN   = 10'b1000000000
   } state_type;

   state_type                  state_ff, state_in;
   logic [1:0]                 k_ff, k_in;
   logic [IW-1:0]              i_ff, i_in;
   logic [SW-1:0]              acc1_ff, acc1_in, acc2_ff, acc2_in, prod_ff, prod_in;
   logic [AW-1:0]              clr_ff, clr_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]              rsp_value_ff, rsp_value_in;
   logic [prqa_pkg::POS_W-1:0] count_ff;
   logic                       start;
   prqa_pkg::plan_type         plan;
   logic                       ram_we;
   logic [AW-1:0]              ram_waddr, ram_raddr;
   logic [2*SW-1:0]            ram_wdata, ram_rdata;
   logic [IW-1:0]              slot_idx;
   logic [SW-1:0]              b1, b2;

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign start              = req_ch.valid && req_ch.ready;
   assign csr_ch.ready       = 1'b1;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.point_value = rsp_value_ff;
   assign b1 = ram_rdata[SW-1:0];
   assign b2 = ram_rdata[2*SW-1:SW];

   prqa_prep #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_prep (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .cmd        (req_ch.cmd),
      .position   (req_ch.position),
      .range_end  (req_ch.range_end),
      .load_value (req_ch.load_value),
      .count      (count_ff),
      .plan_ff    (plan)
   );

   prqa_ram #(.WIDTH(2 * SW), .DEPTH(MAX_ELEMENTS)) u_ram (
      .clock    (clock),
      .we       (ram_we),
      .waddr    (ram_waddr),
      .wdata    (ram_wdata),
      .raddr    (ram_raddr),
      .rdata_ff (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      acc1_in      = acc1_ff;
      acc2_in      = acc2_ff;
      prod_in      = prod_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in = rsp_value_ff;
      ram_we       = 1'b0;
      ram_waddr    = AW'(i_ff - 1'b1);
      ram_raddr    = AW'(i_ff - 1'b1);
      ram_wdata    = '0;
      slot_idx     = '0;

      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST_A) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            k_in    = '0;
            acc1_in = '0;
            acc2_in = '0;
            i_in    = IW'(plan.qpos);
            if (!plan.query) begin
               state_in = S_NEXT;
            end else if (plan.qpos == '0) begin
               state_in = S_MUL;
            end else begin
               state_in = S_QRD;
            end
         end
         S_NEXT: begin
            if (k_ff == 2'd3) begin
               state_in = S_IDLE;
            end else begin
               slot_idx = IW'(plan.idx[k_ff]);
               if (plan.en[k_ff] && slot_idx != '0 && slot_idx <= MAX_I) begin
                  i_in     = slot_idx;
                  state_in = S_RD;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         S_RD: begin
            state_in = S_WR;
         end
         S_WR: begin
            ram_we    = 1'b1;
            ram_wdata = {b2 + plan.d2[k_ff], b1 + plan.d1[k_ff]};
            i_in      = i_ff + (i_ff & (~i_ff + 1'b1));
            if (i_in > MAX_I) begin
               k_in     = k_ff + 1'b1;
               state_in = S_NEXT;
            end else begin
               state_in = S_RD;
            end
         end
         S_QRD: begin
            state_in = S_QACC;
         end
         S_QACC: begin
            acc1_in = acc1_ff + b1;
            acc2_in = acc2_ff + b2;
            i_in    = i_ff & (i_ff - 1'b1);
            state_in = (i_in == '0) ? S_MUL : S_QRD;
         end
         S_MUL: begin
            prod_in  = acc1_ff * SW'(plan.qpos);
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = prod_ff - acc2_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= prqa_pkg::COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid && csr_ch.ready) begin
            count_ff <= csr_ch.element_count;
         end
      end
      i_ff         <= i_in;
      acc1_ff      <= acc1_in;
      acc2_ff      <= acc2_in;
      prod_ff      <= prod_in;
      rsp_value_ff <= rsp_value_in;
   end

   `ASSERT_IMPL(a_wr_states, clock, reset, ram_we, (state_ff == S_CLEAR) || (state_ff == S_WR))
   `ASSERT_IMPL(a_no_req_clear, clock, reset, state_ff == S_CLEAR, !req_ch.ready)
   `ASSERT_NEXT(a_rd_then_wr, clock, reset, state_ff == S_RD, state_ff == S_WR)
   `ASSERT_NEXT(a_rsp_after_fin, clock, reset, (state_ff == S_FIN) && (state_in == S_IDLE),
                rsp_valid_ff)
endmodule

// ===== tb/prqa_checker.sv =====
// Checker for the progression range add / point query block: watches all three channels,
// keeps its own difference-array copy of the state and compares every response.
// Depends on prqa_pkg and prqa_if.
`timescale 1ns / 1ps
module prqa_checker #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic  clock,
   input  logic  reset,
   prqa_req_if   req_ch,
   prqa_rsp_if   rsp_ch,
   prqa_csr_if   csr_ch,
   output int    fail_count,
   output int    pending
);
   logic [prqa_pkg::SUM_W-1:0] diff_q [1:MAX_ELEMENTS];
   logic [prqa_pkg::SUM_W-1:0] value_queue [$];
   logic [prqa_pkg::VAL_W-1:0] last_load;
   logic [prqa_pkg::POS_W-1:0] count_reg;

   assign pending = value_queue.size();

   function automatic int used_count();
      if (count_reg < 1) return 1;
      if (count_reg > MAX_ELEMENTS) return MAX_ELEMENTS;
      return count_reg;
   endfunction

   task automatic apply_item(input logic [1:0] cmd, input int pos, input int rend,
                             input logic [prqa_pkg::VAL_W-1:0] val);
      int n;
      logic [prqa_pkg::SUM_W-1:0] acc;
      n = used_count();
      acc = '0;
      case (cmd)
         prqa_pkg::CMD_LOAD: begin
            if (pos >= 1 && pos <= n) begin
               diff_q[pos] += prqa_pkg::SUM_W'($signed(val))
                              - prqa_pkg::SUM_W'($signed(last_load));
               last_load = val;
            end
         end
         prqa_pkg::CMD_PROG: begin
            if (pos >= 1 && pos <= rend && rend <= n) begin
               for (int i = pos; i <= rend; i++) diff_q[i] += 1;
               if (rend < n) diff_q[rend + 1] -= prqa_pkg::SUM_W'(rend - pos + 1);
            end
         end
         prqa_pkg::CMD_QUERY: begin
            if (pos > n) pos = n;
            for (int i = 1; i <= pos; i++) acc += diff_q[i];
            value_queue = {value_queue, acc};
         end
         default: ;
      endcase
   endtask

   initial begin
      fail_count = 0;
      last_load = '0;
      count_reg = prqa_pkg::COUNT_RESET;
      for (int i = 1; i <= MAX_ELEMENTS; i++) diff_q[i] = '0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         // responses first: a transfer on the same edge belongs to an older query
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (value_queue.size() == 0) begin
               $display("%0t: unexpected response, actual %h", $realtime, rsp_ch.point_value);
               fail_count++;
            end else begin
               if (rsp_ch.point_value !== value_queue[0]) begin
                  $display("%0t: point_value mismatch, expected %h actual %h",
                           $realtime, value_queue[0], rsp_ch.point_value);
                  fail_count++;
               end
               void'(value_queue.pop_front());
            end
         end
         // a request on the same edge still sees the old count
         if (req_ch.valid && req_ch.ready)
            apply_item(req_ch.cmd, req_ch.position, req_ch.range_end, req_ch.load_value);
         if (csr_ch.valid && csr_ch.ready) count_reg = csr_ch.element_count;
      end
   end
endmodule

// ===== tb/tb_top.sv =====
// Top of the testbench: clock, reset, stimulus, register writes and verdict.
// Depends on prqa_pkg, prqa_if, prqa_checker and the block itself.
`timescale 1ns / 1ps
module tb_top;
   localparam int MAXN = 1024;
   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_WAIT = 200;

   logic clock;
   logic reset;
   logic calm;
   logic hold_done;
   int   fail_count;
   int   pending;
   int   quiet_cycles;
   int   cur_count;
   int   cycle_no;

   prqa_req_if req_ch ();
   prqa_rsp_if rsp_ch ();
   prqa_csr_if csr_ch ();

   progression_range_add_point_query #(.MAX_ELEMENTS(MAXN)) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   prqa_checker #(.MAX_ELEMENTS(MAXN)) i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_ch     (csr_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // receiver: random backpressure, one long hold-off once the cycle counter passes a threshold
   initial begin
      int hold;
      hold = 0;
      hold_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && cycle_no > 8000) begin
            hold_done = 1'b1;
            hold = 600;
         end
         if (hold > 0) begin
            hold--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 36);
         end
      end
   end

   task automatic send_item(input logic [1:0] cmd, input int pos, input int rend,
                            input logic [prqa_pkg::VAL_W-1:0] val);
      while (!calm && $urandom_range(99) < 36) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.cmd        <= cmd;
      req_ch.position   <= pos[prqa_pkg::POS_W-1:0];
      req_ch.range_end  <= rend[prqa_pkg::POS_W-1:0];
      req_ch.load_value <= val;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic write_count(input int value);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      // updates leave no response; let the last one finish
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_ch.valid         <= 1'b1;
      csr_ch.element_count <= value[prqa_pkg::POS_W-1:0];
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      if (value < 1) cur_count = 1;
      else if (value > MAXN) cur_count = MAXN;
      else cur_count = value;
   endtask

   task automatic random_item();
      int pick;
      int lo;
      int hi;
      pick = $urandom_range(99);
      if (pick < 6) begin
         // noise: any encoding, any positions
         send_item(2'($urandom_range(3)), $urandom_range(2047), $urandom_range(2047),
                   $urandom);
      end else if (pick < 26) begin
         send_item(prqa_pkg::CMD_LOAD, $urandom_range(cur_count, 1), 0, $urandom);
      end else if (pick < 64) begin
         lo = $urandom_range(cur_count, 1);
         if ($urandom_range(3) == 0) hi = $urandom_range(cur_count, lo);
         else hi = (lo + $urandom_range(8) > cur_count) ? cur_count : lo + $urandom_range(8);
         send_item(prqa_pkg::CMD_PROG, lo, hi, $urandom);
      end else begin
         send_item(prqa_pkg::CMD_QUERY, $urandom_range(cur_count, 1), $urandom_range(2047),
                   $urandom);
      end
   endtask

   initial begin
      int counts [7];
      int steps;
      counts = '{0, 2047, 1, 2, 37, 300, 1024};
      calm = 1'b0;
      cycle_no = 0;
      quiet_cycles = 0;
      cur_count = MAXN;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.cmd <= prqa_pkg::CMD_LOAD;
      req_ch.position <= '0;
      req_ch.range_end <= '0;
      req_ch.load_value <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.element_count <= prqa_pkg::COUNT_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, ignored items and saturation
      send_item(prqa_pkg::CMD_LOAD, 1, 0, 32'h7fffffff);
      send_item(prqa_pkg::CMD_LOAD, 2, 2047, 32'h80000000);
      send_item(prqa_pkg::CMD_LOAD, 0, 0, 32'h12345678);
      send_item(prqa_pkg::CMD_LOAD, 1025, 0, 32'h1);
      send_item(prqa_pkg::CMD_LOAD, 2047, 0, 32'hffffffff);
      send_item(prqa_pkg::CMD_LOAD, 1024, 0, 32'hffffffff);
      send_item(prqa_pkg::CMD_PROG, 1, 1024, 0);
      send_item(prqa_pkg::CMD_PROG, 1, 1, 0);
      send_item(prqa_pkg::CMD_PROG, 5, 3, 0);
      send_item(prqa_pkg::CMD_PROG, 0, 3, 0);
      send_item(prqa_pkg::CMD_PROG, 1000, 1025, 0);
      send_item(prqa_pkg::CMD_PROG, 1023, 1024, 0);
      send_item(prqa_pkg::CMD_PROG, 2, 1023, 0);
      send_item(prqa_pkg::CMD_QUERY, 0, 0, 0);
      send_item(prqa_pkg::CMD_QUERY, 1, 0, 0);
      send_item(prqa_pkg::CMD_QUERY, 2, 0, 0);
      send_item(prqa_pkg::CMD_QUERY, 1024, 0, 0);
      send_item(prqa_pkg::CMD_QUERY, 2047, 0, 0);
      send_item(prqa_pkg::CMD_QUERY, 1500, 0, 0);
      send_item(prqa_pkg::CMD_QUERY, 1023, 0, 0);
      send_item(prqa_pkg::CMD_SPARE, 7, 9, 32'hdeadbeef);

      for (int p = 0; p < 7; p++) begin
         write_count(counts[p]);
         steps = 0;
         // well-formed prefix: loads in index order
         for (int i = 1; i <= cur_count && i <= 40; i++) begin
            send_item(prqa_pkg::CMD_LOAD, i, 0, $urandom);
            steps++;
         end
         calm = (p == 5);
         for (int k = steps; k < 280; k++) random_item();
         calm = 1'b0;
      end

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+src
src/prqa_pkg.sv
src/prqa_if.sv
src/prqa_ram.sv
src/prqa_prep.sv
src/progression_range_add_point_query.sv
tb/prqa_checker.sv
tb/tb_top.sv
